// File: src/jsb_pkg.sv
`default_nettype none
package jsb_pkg;

    // Job set and encoding
    localparam int unsigned NUM_JOBS   = 5;
    localparam int unsigned JOB_W      = 3;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned TIME_W     = 32;

    localparam logic [JOB_W-1:0] JOB_LOCAL    = 3'd0;
    localparam logic [JOB_W-1:0] JOB_WEATHER  = 3'd1;
    localparam logic [JOB_W-1:0] JOB_INET     = 3'd2;
    localparam logic [JOB_W-1:0] JOB_RADAR    = 3'd3;
    localparam logic [JOB_W-1:0] JOB_FORECAST = 3'd4;

    // Selection order, highest priority first
    localparam logic [JOB_W-1:0] PRIO_ORDER [NUM_JOBS] =
        '{JOB_LOCAL, JOB_INET, JOB_WEATHER, JOB_RADAR, JOB_FORECAST};

    // Stream widths
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 48;

    // Register file
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [2:0] REG_INET_FIRST  = 3'd0;
    localparam logic [2:0] REG_INET_SECOND = 3'd1;
    localparam logic [2:0] REG_INET_MAX    = 3'd2;
    localparam logic [2:0] REG_DEFER_RETRY = 3'd3;
    localparam logic [2:0] REG_FORCE_AFTER = 3'd4;

    localparam logic [TIME_W-1:0] RST_INET_FIRST  = 32'd15000;
    localparam logic [TIME_W-1:0] RST_INET_SECOND = 32'd30000;
    localparam logic [TIME_W-1:0] RST_INET_MAX    = 32'd60000;
    localparam logic [TIME_W-1:0] RST_DEFER_RETRY = 32'd10000;
    localparam logic [CNT_W-1:0]  RST_FORCE_AFTER = 8'd3;

    // Commands carried in tuser
    typedef enum logic [2:0] {
        ACT_REQUEST = 3'd0,
        ACT_SELECT  = 3'd1,
        ACT_FINISH  = 3'd2,
        ACT_PAUSE   = 3'd3,
        ACT_GUARD   = 3'd4,
        ACT_CONSUME = 3'd5
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] inet_first;
        logic [TIME_W-1:0] inet_second;
        logic [TIME_W-1:0] inet_max;
        logic [TIME_W-1:0] defer_retry;
        logic [CNT_W-1:0]  force_after;
    } t_cfg;

    typedef struct packed {
        logic              low_memory;
        logic              pause_value;
        logic              was_deferred;
        logic              succeeded;
        logic [TIME_W-1:0] now_ms;
        logic              force_req;
        logic [JOB_W-1:0]  job_id;
    } t_item;

    typedef struct packed {
        logic              is_busy;
        logic [2:0]        pending_count;
        logic [TIME_W-1:0] retry_delay_ms;
        logic              recovery_flag;
        logic              guard_deferred;
        logic [JOB_W-1:0]  selected_job;
        logic              selected_valid;
        logic              accepted;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } t_dp_status;

    // Deadline still ahead of now (wrap-safe); zero means none
    function automatic logic dl_pending(logic [TIME_W-1:0] now, logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] d;
        d = dl - now;
        return (dl != '0) && (d != '0) && !d[TIME_W-1];
    endfunction

    // Capped exponential backoff for the jobs with fixed bases
    function automatic logic [TIME_W-1:0] table_backoff(logic [JOB_W-1:0] job,
                                                        logic [CNT_W-1:0] fails);
        logic [2:0]        expo;
        logic [TIME_W-1:0] v;
        expo = (fails > 8'd4) ? 3'd4 : fails[2:0];
        case (job)
            JOB_LOCAL: begin
                case (expo)
                    3'd2:    v = 32'd10000;
                    3'd3:    v = 32'd20000;
                    3'd4:    v = 32'd30000;
                    default: v = 32'd5000;
                endcase
            end
            JOB_RADAR: begin
                case (expo)
                    3'd2:    v = 32'd120000;
                    3'd3:    v = 32'd240000;
                    3'd4:    v = 32'd300000;
                    default: v = 32'd60000;
                endcase
            end
            JOB_FORECAST: begin
                case (expo)
                    3'd2:    v = 32'd240000;
                    3'd3:    v = 32'd480000;
                    3'd4:    v = 32'd900000;
                    default: v = 32'd120000;
                endcase
            end
            default: begin
                case (expo)
                    3'd2:    v = 32'd60000;
                    3'd3:    v = 32'd120000;
                    3'd4:    v = 32'd240000;
                    default: v = 32'd30000;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/jsb_regs.sv
`default_nettype none
module jsb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jsb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [jsb_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [jsb_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output jsb_pkg::t_cfg                       o_cfg
);
    import jsb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inet_first  <= RST_INET_FIRST;
            r_cfg.inet_second <= RST_INET_SECOND;
            r_cfg.inet_max    <= RST_INET_MAX;
            r_cfg.defer_retry <= RST_DEFER_RETRY;
            r_cfg.force_after <= RST_FORCE_AFTER;
        end else if (wr_en) begin
            case (reg_idx)
                REG_INET_FIRST:  r_cfg.inet_first  <= pwdata;
                REG_INET_SECOND: r_cfg.inet_second <= pwdata;
                REG_INET_MAX:    r_cfg.inet_max    <= pwdata;
                REG_DEFER_RETRY: r_cfg.defer_retry <= pwdata;
                REG_FORCE_AFTER: r_cfg.force_after <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_INET_FIRST:  prdata = r_cfg.inet_first;
            REG_INET_SECOND: prdata = r_cfg.inet_second;
            REG_INET_MAX:    prdata = r_cfg.inet_max;
            REG_DEFER_RETRY: prdata = r_cfg.defer_retry;
            REG_FORCE_AFTER: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_cfg.force_after};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: src/jsb_ctrl.sv
`default_nettype none
module jsb_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire jsb_pkg::t_dp_status i_status,
    output logic                     o_in_ready,
    output jsb_pkg::t_dp_cmd         o_cmd
);
    import jsb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_status.slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = i_status.slot_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: src/jsb_dp.sv
`default_nettype none
module jsb_dp #(
    parameter int unsigned COUNT_LIMIT = 255
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire jsb_pkg::t_dp_cmd                i_cmd,
    input  wire logic [jsb_pkg::IN_DATA_W-1:0]   i_tdata,
    input  wire logic [jsb_pkg::IN_USER_W-1:0]   i_tuser,
    input  wire jsb_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_out_ready,
    output jsb_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    output logic      [jsb_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import jsb_pkg::*;

    localparam logic [CNT_W-1:0] CntLimit = CNT_W'(COUNT_LIMIT);

    // Captured request
    t_item              r_item;
    logic [2:0]         r_action;

    // Scheduler state
    logic [NUM_JOBS-1:0] r_pending, n_pending;
    logic                r_run_valid, n_run_valid;
    logic [JOB_W-1:0]    r_run_job, n_run_job;
    logic                r_paused, n_paused;
    logic                r_recovery, n_recovery;
    logic [TIME_W-1:0]   r_deadline [NUM_JOBS];
    logic [TIME_W-1:0]   n_deadline [NUM_JOBS];
    logic [CNT_W-1:0]    r_fail [NUM_JOBS];
    logic [CNT_W-1:0]    n_fail [NUM_JOBS];
    logic [CNT_W-1:0]    r_defer [NUM_JOBS];
    logic [CNT_W-1:0]    n_defer [NUM_JOBS];

    // Output slot
    logic                r_out_valid;
    t_result             r_out;
    t_result             res;

    // Work signals
    logic                job_ok;
    logic [JOB_W-1:0]    ji;
    logic [NUM_JOBS-1:0] dl_due;
    logic [CNT_W-1:0]    fail_inc;
    logic [CNT_W-1:0]    defer_inc;
    logic [TIME_W-1:0]   backoff;
    logic [TIME_W-1:0]   fin_delay;
    logic                found;
    logic [JOB_W-1:0]    cand;
    logic [2:0]          pcount;

    assign o_status.slot_free = !r_out_valid || i_out_ready;

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= t_item'(i_tdata);
            r_action <= i_tuser;
        end
    end

    assign job_ok = r_item.job_id < JOB_W'(NUM_JOBS);
    assign ji     = job_ok ? r_item.job_id : JOB_LOCAL;

    // Deadline checks for every job
    always_comb begin
        for (int k = 0; k < NUM_JOBS; k++) begin
            dl_due[k] = dl_pending(r_item.now_ms, r_deadline[k]);
        end
    end

    // Saturating counts and backoff delay
    assign fail_inc  = (r_fail[ji]  < CntLimit) ? r_fail[ji]  + 1'b1 : r_fail[ji];
    assign defer_inc = (r_defer[ji] < CntLimit) ? r_defer[ji] + 1'b1 : r_defer[ji];

    always_comb begin
        if (ji == JOB_INET) begin
            if (fail_inc <= 8'd1)      backoff = i_cfg.inet_first;
            else if (fail_inc == 8'd2) backoff = i_cfg.inet_second;
            else                       backoff = i_cfg.inet_max;
        end else begin
            backoff = table_backoff(ji, fail_inc);
        end
    end

    assign fin_delay = r_item.was_deferred ? i_cfg.defer_retry : backoff;

    // Command execution
    always_comb begin
        n_pending   = r_pending;
        n_run_valid = r_run_valid;
        n_run_job   = r_run_job;
        n_paused    = r_paused;
        n_recovery  = r_recovery;
        n_deadline  = r_deadline;
        n_fail      = r_fail;
        n_defer     = r_defer;
        res         = '0;
        found       = 1'b0;
        cand        = JOB_LOCAL;

        case (r_action)
            ACT_REQUEST: begin
                if (job_ok && !r_paused && (r_item.force_req || !dl_due[ji])) begin
                    if (r_item.force_req) n_deadline[ji] = '0;
                    if (!r_pending[ji] && !(r_run_valid && r_run_job == ji)) begin
                        n_pending[ji] = 1'b1;
                        res.accepted  = 1'b1;
                    end
                end
            end
            ACT_SELECT: begin
                // Drop pending jobs in priority order until one is due
                if (!r_paused) begin
                    for (int k = 0; k < NUM_JOBS; k++) begin
                        cand = PRIO_ORDER[k];
                        if (!found && r_pending[cand]) begin
                            n_pending[cand] = 1'b0;
                            if (!dl_due[cand]) begin
                                found              = 1'b1;
                                n_run_valid        = 1'b1;
                                n_run_job          = cand;
                                res.selected_valid = 1'b1;
                                res.selected_job   = cand;
                            end
                        end
                    end
                end
            end
            ACT_FINISH: begin
                n_run_valid = 1'b0;
                n_run_job   = JOB_LOCAL;
                if (job_ok) begin
                    if (!r_item.was_deferred && r_item.succeeded) begin
                        n_fail[ji]     = '0;
                        n_deadline[ji] = '0;
                    end else begin
                        if (!r_item.was_deferred) n_fail[ji] = fail_inc;
                        n_deadline[ji]     = r_item.now_ms + fin_delay;
                        res.retry_delay_ms = fin_delay;
                    end
                end
            end
            ACT_PAUSE: begin
                n_paused = r_item.pause_value;
                if (r_item.pause_value) n_pending = '0;
            end
            ACT_GUARD: begin
                if (!job_ok || ji == JOB_LOCAL || !r_item.low_memory) begin
                    if (job_ok && ji != JOB_LOCAL) n_defer[ji] = '0;
                    res.accepted = 1'b1;
                end else if (defer_inc >= i_cfg.force_after) begin
                    // Forced attempt after enough deferrals
                    n_defer[ji]  = '0;
                    res.accepted = 1'b1;
                end else begin
                    n_defer[ji]        = defer_inc;
                    n_recovery         = 1'b1;
                    res.guard_deferred = 1'b1;
                end
            end
            ACT_CONSUME: begin
                res.recovery_flag = r_recovery;
                n_recovery        = 1'b0;
            end
            default: ;
        endcase

        // Status after the command
        pcount = '0;
        for (int k = 0; k < NUM_JOBS; k++) begin
            pcount = pcount + {2'b00, n_pending[k]};
        end
        res.pending_count = pcount;
        res.is_busy       = n_run_valid || (n_pending != '0);
    end

    // State update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_run_valid <= 1'b0;
            r_run_job   <= '0;
            r_paused    <= 1'b0;
            r_recovery  <= 1'b0;
            for (int k = 0; k < NUM_JOBS; k++) begin
                r_deadline[k] <= '0;
                r_fail[k]     <= '0;
                r_defer[k]    <= '0;
            end
        end else if (i_cmd.commit) begin
            r_pending   <= n_pending;
            r_run_valid <= n_run_valid;
            r_run_job   <= n_run_job;
            r_paused    <= n_paused;
            r_recovery  <= n_recovery;
            r_deadline  <= n_deadline;
            r_fail      <= n_fail;
            r_defer     <= n_defer;
        end
    end

    // Output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_DATA_W-$bits(t_result)){1'b0}}, r_out};

endmodule
`default_nettype wire

// File: src/job_scheduler_with_backoff.sv
`default_nettype none
// Flow: an accepted request is captured, then executed in the controller's execute state
//   once the result slot is free; its result is registered and presented on m_axis_tdata.
//   A stalled result holds the execute step, and no new request is taken until it runs.
// Reset: i_rst_n synchronous, active low; clears all scheduler state and loads
//   the configuration registers with their default values.
module job_scheduler_with_backoff #(
    parameter int unsigned COUNT_LIMIT = 255
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [2:0] job_id, [3] force_req, [35:4] now_ms, [36] succeeded,
    // [37] was_deferred, [38] pause_value, [39] low_memory
    input  wire logic [jsb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] action
    input  wire logic [jsb_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] accepted, [1] selected_valid, [4:2] selected_job, [5] guard_deferred,
    // [6] recovery_flag, [38:7] retry_delay_ms, [41:39] pending_count,
    // [42] is_busy, [47:43] zero
    output logic      [jsb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [jsb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [jsb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [jsb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import jsb_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    jsb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    jsb_dp #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg       (cfg),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // Execute only into a free output slot
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> status.slot_free)
        else $error("commit while result slot occupied");

    // A captured request is executed before the next one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !s_axis_tready)
        else $error("new request taken before execute");

    // Every execute presents a result in the next cycle
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("result missing after execute");

    // Pending count never exceeds the job count
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[41:39] <= 3'd5))
        else $error("pending count out of range");
`endif

endmodule
`default_nettype wire

// File: bench/job_scheduler_with_backoff_tb.sv
import jsb_pkg::*;

// Failure and deferral counters stop here
localparam logic [CNT_W-1:0] SAT_COUNT = 8'd255;

// Shadow scheduler: tracks the job state and holds the outcomes still owed by the block
class sched_tracker;
    // register copies
    logic [TIME_W-1:0]   inet_first;
    logic [TIME_W-1:0]   inet_second;
    logic [TIME_W-1:0]   inet_max;
    logic [TIME_W-1:0]   defer_retry;
    logic [CNT_W-1:0]    force_after;
    // scheduler state
    logic [NUM_JOBS-1:0] pend_mask;
    logic                run_valid;
    logic [JOB_W-1:0]    run_job;
    logic                paused;
    logic                recovery;
    logic [TIME_W-1:0]   deadline [NUM_JOBS];
    logic [CNT_W-1:0]    fails    [NUM_JOBS];
    logic [CNT_W-1:0]    defers   [NUM_JOBS];
    // outcomes owed, oldest first
    t_result             outcome_q [$];
    int unsigned         fail_count;
    int unsigned         seen;

    function new();
        inet_first  = RST_INET_FIRST;
        inet_second = RST_INET_SECOND;
        inet_max    = RST_INET_MAX;
        defer_retry = RST_DEFER_RETRY;
        force_after = RST_FORCE_AFTER;
        pend_mask   = '0;
        run_valid   = 1'b0;
        run_job     = '0;
        paused      = 1'b0;
        recovery    = 1'b0;
        for (int i = 0; i < NUM_JOBS; i++) begin
            deadline[i] = '0;
            fails[i]    = '0;
            defers[i]   = '0;
        end
        fail_count = 0;
        seen       = 0;
    endfunction

    function void load_register(logic [2:0] idx, logic [APB_DATA_W-1:0] val);
        case (idx)
            REG_INET_FIRST:  inet_first  = val;
            REG_INET_SECOND: inet_second = val;
            REG_INET_MAX:    inet_max    = val;
            REG_DEFER_RETRY: defer_retry = val;
            REG_FORCE_AFTER: force_after = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Deadline still in the future, wrap-safe; zero means none armed
    function logic deadline_ahead(logic [TIME_W-1:0] now, logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] d;
        d = dl - now;
        return (dl != '0) && (d != '0) && !d[TIME_W-1];
    endfunction

    // Retry delay after the n-th consecutive failure
    function logic [TIME_W-1:0] backoff_ms(logic [JOB_W-1:0] job, logic [CNT_W-1:0] n);
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] cap;
        logic [TIME_W-1:0] v;
        int unsigned       expo;
        if (job == JOB_INET) begin
            if (n <= 8'd1) return inet_first;
            if (n == 8'd2) return inet_second;
            return inet_max;
        end
        case (job)
            JOB_LOCAL:    begin base = 32'd5000;   cap = 32'd30000;  end
            JOB_RADAR:    begin base = 32'd60000;  cap = 32'd300000; end
            JOB_FORECAST: begin base = 32'd120000; cap = 32'd900000; end
            default:      begin base = 32'd30000;  cap = 32'd300000; end
        endcase
        expo = (n > 8'd4) ? 4 : int'(n);
        v = base;
        for (int unsigned i = 1; i < expo; i++) begin
            if (v >= (cap >> 1)) return cap;
            v = v << 1;
        end
        return (v > cap) ? cap : v;
    endfunction

    // Apply one accepted request and queue the outcome it owes
    function void note_command(logic [2:0] act, t_item it);
        t_result             r;
        logic [JOB_W-1:0]    job;
        logic [JOB_W-1:0]    c;
        logic                job_ok;
        logic [NUM_JOBS-1:0] bit_m;
        logic [TIME_W-1:0]   b;
        r      = '0;
        job    = it.job_id;
        job_ok = (job < JOB_W'(NUM_JOBS));
        case (act)
            ACT_REQUEST: begin
                if (job_ok && !paused &&
                    (it.force_req || !deadline_ahead(it.now_ms, deadline[job]))) begin
                    bit_m = NUM_JOBS'(1) << job;
                    // forced request drops the deadline even if refused below
                    if (it.force_req) deadline[job] = '0;
                    if ((pend_mask & bit_m) == '0 && !(run_valid && run_job == job)) begin
                        pend_mask  = pend_mask | bit_m;
                        r.accepted = 1'b1;
                    end
                end
            end
            ACT_SELECT: begin
                if (!paused && pend_mask != '0) begin
                    for (int i = 0; i < NUM_JOBS && !r.selected_valid; i++) begin
                        c = PRIO_ORDER[i];
                        if (pend_mask[c]) begin
                            // backed-off job loses its pending bit
                            pend_mask[c] = 1'b0;
                            if (!deadline_ahead(it.now_ms, deadline[c])) begin
                                run_valid        = 1'b1;
                                run_job          = c;
                                r.selected_valid = 1'b1;
                                r.selected_job   = c;
                            end
                        end
                    end
                end
            end
            ACT_FINISH: begin
                run_valid = 1'b0;
                run_job   = '0;
                if (job_ok) begin
                    if (it.was_deferred) begin
                        r.retry_delay_ms = defer_retry;
                        deadline[job]    = it.now_ms + defer_retry;
                    end else if (it.succeeded) begin
                        fails[job]    = '0;
                        deadline[job] = '0;
                    end else begin
                        if (fails[job] < SAT_COUNT) fails[job] = fails[job] + 8'd1;
                        b                = backoff_ms(job, fails[job]);
                        deadline[job]    = it.now_ms + b;
                        r.retry_delay_ms = b;
                    end
                end
            end
            ACT_PAUSE: begin
                paused = it.pause_value;
                if (it.pause_value) pend_mask = '0;
            end
            ACT_GUARD: begin
                if (!job_ok || job == JOB_LOCAL || !it.low_memory) begin
                    if (job_ok && job != JOB_LOCAL) defers[job] = '0;
                    r.accepted = 1'b1;
                end else begin
                    if (defers[job] < SAT_COUNT) defers[job] = defers[job] + 8'd1;
                    if (defers[job] >= force_after) begin
                        defers[job] = '0;
                        r.accepted  = 1'b1;
                    end else begin
                        recovery         = 1'b1;
                        r.guard_deferred = 1'b1;
                    end
                end
            end
            ACT_CONSUME: begin
                r.recovery_flag = recovery;
                recovery        = 1'b0;
            end
            default: ;
        endcase
        r.pending_count = 3'($countones(pend_mask));
        r.is_busy       = run_valid || (pend_mask != '0);
        outcome_q.push_back(r);
    endfunction

    task report(string msg);
        $display("MISMATCH %s", msg);
        fail_count++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0h, expected %0h", seen, name, got, want));
    endtask

    task check_outcome(logic [OUT_DATA_W-1:0] word);
        t_result got;
        t_result want;
        got = word[$bits(t_result)-1:0];
        seen++;
        if (outcome_q.size() == 0) begin
            report($sformatf("result %0d arrived with none outstanding", seen));
            return;
        end
        want = outcome_q.pop_front();
        compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
        compare_field("selected_valid", 32'(got.selected_valid), 32'(want.selected_valid));
        compare_field("selected_job", 32'(got.selected_job), 32'(want.selected_job));
        compare_field("guard_deferred", 32'(got.guard_deferred), 32'(want.guard_deferred));
        compare_field("recovery_flag", 32'(got.recovery_flag), 32'(want.recovery_flag));
        compare_field("retry_delay_ms", got.retry_delay_ms, want.retry_delay_ms);
        compare_field("pending_count", 32'(got.pending_count), 32'(want.pending_count));
        compare_field("is_busy", 32'(got.is_busy), 32'(want.is_busy));
        compare_field("pad", 32'(word[OUT_DATA_W-1:$bits(t_result)]), 32'd0);
    endtask
endclass

module job_scheduler_with_backoff_tb;

    localparam logic [2:0]  ACT_SPARE6    = 3'd6;
    localparam logic [2:0]  ACT_SPARE7    = 3'd7;
    localparam int          MIX_GENERAL   = 0;
    localparam int          MIX_FAILURES  = 1;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sched_tracker          tracker;
    logic [TIME_W-1:0]     clock_ms     = 32'd0;
    bit                    calm         = 1'b0;
    int unsigned           hold_asked   = 0;
    int unsigned           cycle_count  = 0;

    job_scheduler_with_backoff u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Handshake monitor: requests in, then results out, on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_command(s_axis_tuser, t_item'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_outcome(m_axis_tdata);
        end
    end

    // Result side backpressure: random bursts, one long hold when asked, none when calm
    initial begin : result_sink
        int unsigned hold_served;
        hold_served = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 1) == 0) begin
                m_axis_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("job_scheduler_with_backoff verification failed");
        $finish;
    end

    // Offer one request and hold it until taken; sometimes idle afterwards
    task automatic issue(logic [2:0] act, t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= it;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic issue_cmd(logic [2:0] act, logic [JOB_W-1:0] job, logic [TIME_W-1:0] now,
                             logic frc, logic ok, logic dfr, logic pv, logic lm);
        t_item it;
        it.job_id       = job;
        it.force_req    = frc;
        it.now_ms       = now;
        it.succeeded    = ok;
        it.was_deferred = dfr;
        it.pause_value  = pv;
        it.low_memory   = lm;
        issue(act, it);
    endtask

    // Stop offering and wait until every owed outcome is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        tracker.load_register(idx, val);
    endtask

    task automatic configure(logic [31:0] f_ms, logic [31:0] s_ms, logic [31:0] m_ms,
                             logic [31:0] d_ms, logic [7:0] thresh);
        write_reg(REG_INET_FIRST, f_ms);
        write_reg(REG_INET_SECOND, s_ms);
        write_reg(REG_INET_MAX, m_ms);
        write_reg(REG_DEFER_RETRY, d_ms);
        write_reg(REG_FORCE_AFTER, {24'd0, thresh});
    endtask

    // One random command; time mostly creeps forward so backoffs expire now and then
    task automatic random_command(int mix);
        logic [63:0] raw;
        t_item       it;
        logic [2:0]  act;
        int unsigned pick;
        raw  = {$urandom(), $urandom()};
        it   = raw[IN_DATA_W-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 2) clock_ms = $urandom();
        it.now_ms = (pick == 99) ? $urandom() : clock_ms;
        clock_ms  = clock_ms + $urandom_range(0, 4000);
        it.job_id = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (mix == MIX_FAILURES) begin
            // hammer failures to push the counters into saturation
            if (pick < 95) begin
                act             = ACT_FINISH;
                it.job_id       = ($urandom_range(0, 9) != 0) ? JOB_INET : JOB_LOCAL;
                it.was_deferred = 1'b0;
                it.succeeded    = 1'b0;
            end else begin
                act = ACT_REQUEST;
            end
        end else if (pick < 30) begin
            act          = ACT_REQUEST;
            it.force_req = ($urandom_range(0, 4) == 0);
        end else if (pick < 50) begin
            act = ACT_SELECT;
        end else if (pick < 70) begin
            act = ACT_FINISH;
            if (tracker.run_valid && $urandom_range(0, 4) != 0) it.job_id = tracker.run_job;
            it.was_deferred = ($urandom_range(0, 4) == 0);
        end else if (pick < 85) begin
            act           = ACT_GUARD;
            it.low_memory = ($urandom_range(0, 3) != 0);
        end else if (pick < 90) begin
            act            = ACT_PAUSE;
            it.pause_value = tracker.paused ? ($urandom_range(0, 4) == 0)
                                            : ($urandom_range(0, 5) == 0);
        end else if (pick < 97) begin
            act = ACT_CONSUME;
        end else begin
            act = ($urandom_range(0, 1) == 0) ? ACT_SPARE6 : ACT_SPARE7;
        end
        issue(act, it);
    endtask

    task automatic run_phase(int unsigned count, int mix);
        repeat (count) random_command(mix);
    endtask

    initial begin : stimulus
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at reset defaults
        // dedup against pending and running, priority, replacement of the running job
        issue_cmd(ACT_REQUEST, JOB_LOCAL, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_LOCAL, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_INET, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_LOCAL, 32'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd300, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // backoff refuses, force clears it
        issue_cmd(ACT_FINISH, JOB_INET, 32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_INET, 32'd2000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_INET, 32'd2000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd2100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // deferral beats success; deadline sum wraps to zero
        issue_cmd(ACT_FINISH, JOB_INET, 32'hFFFF_D8F0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_INET, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_REQUEST, 3'd5, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // pending job that gets backed off is skipped by select
        issue_cmd(ACT_REQUEST, JOB_RADAR, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_FINISH, JOB_RADAR, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // pause drops pending and blocks request and select
        issue_cmd(ACT_REQUEST, JOB_WEATHER, 32'd20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_PAUSE, JOB_LOCAL, 32'd30, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        issue_cmd(ACT_REQUEST, JOB_FORECAST, 32'd40, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_SELECT, JOB_LOCAL, 32'd50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue_cmd(ACT_PAUSE, JOB_LOCAL, 32'd60, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // guard defers twice, then forces an attempt; recovery read and cleared
        repeat (3) issue_cmd(ACT_GUARD, JOB_WEATHER, 32'd70, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        repeat (2) issue_cmd(ACT_CONSUME, JOB_LOCAL, 32'd80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // out-of-range and local feed never deferred; stray finish; unused action
        issue_cmd(ACT_GUARD, 3'd7, 32'd90, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        issue_cmd(ACT_GUARD, JOB_LOCAL, 32'd90, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        issue_cmd(ACT_FINISH, 3'd6, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        issue(ACT_SPARE7, '1);
        settle();

        // Realistic delays
        configure($urandom_range(1000, 40000), $urandom_range(1000, 80000),
                  $urandom_range(1000, 200000), $urandom_range(1000, 30000),
                  8'($urandom_range(1, 6)));
        clock_ms = 32'hFFF8_0000;
        run_phase(200, MIX_GENERAL);
        settle();

        // Register extremes, with a long result hold that backs up the input
        configure(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1);
        run_phase(60, MIX_GENERAL);
        hold_asked++;
        run_phase(40, MIX_GENERAL);
        run_phase(50, MIX_GENERAL);
        settle();

        // Failure counter saturation, top threshold
        configure($urandom(), $urandom(), $urandom(), $urandom(), 8'd255);
        run_phase(320, MIX_FAILURES);
        settle();

        // Zero max and deferral delays, zero threshold: every low-memory check forces
        configure(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 8'd0);
        clock_ms = 32'hFFFE_0000;
        run_phase(150, MIX_GENERAL);
        settle();

        // Mixed settings, then a stretch with no idling on either side
        configure($urandom_range(0, 50000), $urandom_range(0, 100000),
                  $urandom_range(0, 300000), $urandom_range(0, 40000),
                  8'($urandom_range(2, 8)));
        run_phase(90, MIX_GENERAL);
        calm = 1'b1;
        run_phase(80, MIX_GENERAL);
        settle();

        if (tracker.fail_count == 0) begin
            $display("job_scheduler_with_backoff verification clean");
        end else begin
            $display("job_scheduler_with_backoff verification failed");
        end
        $finish;
    end

endmodule
